FILE: design/hat_pkg.sv
// Shared types and constants of the host address table.
// Used by the controller, the datapath, the top level and the port checker.
package hat_pkg;

    // Field widths of one request and one result.
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int ID_W   = 32;
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int STAT_W = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 88;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POPULATE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP        = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_HIT      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    // Hash: Horner sum over the four address bytes with multiplier 13.
    // The largest sum is 255 * (2197 + 169 + 13 + 1), which fits in 20 bits.
    localparam int HASH_ACC_W = 20;
    localparam int HASH_MULT  = 13;
    localparam int ADDR_BYTES = 4;
    // Fraction bits of the reciprocal used for the bucket reduction.
    localparam int RECIP_SHIFT = 21;

    // One stored way of a bucket.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   ident;
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
    } way_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_en;
        logic item_load;
        logic hash_en;
        logic quot_en;
        logic prod_en;
        logic read_en;
        logic commit_en;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/hat_ctrl.sv
// Sequencer of the host address table: clearing pass, hash steps, bucket
// read and commit. Depends on hat_pkg for the command and status structs.
module hat_ctrl
    import hat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  dp_cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_HASH   = 7'b0000100,
        ST_QUOT   = 7'b0001000,
        ST_PROD   = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (dp_status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_HASH;
            end
            ST_HASH:  state_next = ST_QUOT;
            ST_QUOT:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_READ;
            ST_READ:  state_next = ST_COMMIT;
            ST_COMMIT: begin
                // The result register must be free before the bucket is updated.
                if (dp_status.out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        dp_cmd           = '0;
        dp_cmd.clear_en  = (state_reg == ST_CLEAR);
        dp_cmd.item_load = (state_reg == ST_IDLE) && s_tvalid;
        dp_cmd.hash_en   = (state_reg == ST_HASH);
        dp_cmd.quot_en   = (state_reg == ST_QUOT);
        dp_cmd.prod_en   = (state_reg == ST_PROD);
        dp_cmd.read_en   = (state_reg == ST_READ);
        dp_cmd.commit_en = (state_reg == ST_COMMIT) && dp_status.out_free;
    end

endmodule

FILE: design/hat_dp.sv
// Datapath of the host address table: request registers, bucket hash and
// reduction, bucket memory, way search, update and result register. Uses hat_pkg.
module hat_dp
    import hat_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024,
    parameter int BUCKET_WAYS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            dp_cmd,
    output dp_status_t           dp_status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FILL_W    = $clog2(BUCKET_WAYS + 1);
    localparam int WAY_IDX_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int WAY_W     = $bits(way_t);
    localparam int ROW_W     = FILL_W + BUCKET_WAYS * WAY_W;
    localparam int NB_W      = $clog2(NUM_BUCKETS + 1);
    localparam int RPROD_W   = HASH_ACC_W + RECIP_SHIFT;
    localparam int QPROD_W   = HASH_ACC_W + NB_W;

    localparam logic [RECIP_SHIFT-1:0] RECIP   = RECIP_SHIFT'((2 ** RECIP_SHIFT) / NUM_BUCKETS);
    localparam logic [NB_W-1:0]        NB_CONST = NB_W'(NUM_BUCKETS);
    localparam logic [HASH_ACC_W-1:0]  NB_ACC   = HASH_ACC_W'(NUM_BUCKETS);
    localparam logic [FILL_W-1:0]      WAYS_FILL = FILL_W'(BUCKET_WAYS);

    // Request registers.
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  addr_reg;
    logic [ID_W-1:0]   gid_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [USEC_W-1:0] usec_reg;

    always_ff @(posedge aclk) begin
        if (dp_cmd.item_load) begin
            cmd_reg  <= s_tdata[CMD_W-1:0];
            addr_reg <= s_tdata[CMD_W +: KEY_W];
            gid_reg  <= s_tdata[CMD_W + KEY_W +: ID_W];
            sec_reg  <= s_tdata[CMD_W + KEY_W + ID_W +: SEC_W];
            usec_reg <= s_tdata[CMD_W + KEY_W + ID_W + SEC_W +: USEC_W];
        end
    end

    // Hash sum, then bucket = sum mod NUM_BUCKETS by reciprocal multiply.
    // The quotient estimate is exact or one low, so one correction suffices.
    logic [HASH_ACC_W-1:0] hash_acc;
    logic [HASH_ACC_W-1:0] acc_reg;
    logic [RPROD_W-1:0]    recip_prod;
    logic [HASH_ACC_W-1:0] quot_reg;
    logic [QPROD_W-1:0]    qn_prod;
    logic [HASH_ACC_W-1:0] qprod_reg;
    logic [HASH_ACC_W-1:0] rem_raw;
    logic [HASH_ACC_W-1:0] rem_fix;
    logic [BKT_W-1:0]      bucket_next;

    always_comb begin
        hash_acc = '0;
        for (int k = 0; k < ADDR_BYTES; k++) begin
            hash_acc = HASH_ACC_W'(hash_acc * HASH_MULT)
                     + HASH_ACC_W'(addr_reg[KEY_W-1-8*k -: 8]);
        end
    end

    assign recip_prod  = RPROD_W'(acc_reg) * RPROD_W'(RECIP);
    assign qn_prod     = QPROD_W'(quot_reg) * QPROD_W'(NB_CONST);
    assign rem_raw     = acc_reg - qprod_reg;
    assign rem_fix     = (rem_raw >= NB_ACC) ? (rem_raw - NB_ACC) : rem_raw;
    assign bucket_next = rem_fix[BKT_W-1:0];

    always_ff @(posedge aclk) begin
        if (dp_cmd.hash_en) acc_reg   <= hash_acc;
        if (dp_cmd.quot_en) quot_reg  <= recip_prod[RPROD_W-1:RECIP_SHIFT];
        if (dp_cmd.prod_en) qprod_reg <= qn_prod[HASH_ACC_W-1:0];
    end

    // Bucket memory: one row per bucket, a fill count and the ways.
    logic [ROW_W-1:0] bucket_mem [NUM_BUCKETS];
    logic [ROW_W-1:0] row_reg;
    logic [BKT_W-1:0] bucket_reg;
    logic             mem_we;
    logic [BKT_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) bucket_mem[mem_waddr] <= mem_wdata;
        if (dp_cmd.read_en) begin
            row_reg    <= bucket_mem[bucket_next];
            bucket_reg <= bucket_next;
        end
    end

    // Clearing pass after reset: every row gets a fill count of zero.
    logic [BKT_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (dp_cmd.clear_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Way search. Ways fill in order, so a way is valid below the fill count.
    way_t [BUCKET_WAYS-1:0] rd_ways;
    logic [FILL_W-1:0]      rd_fill;
    logic                   found;
    logic [WAY_IDX_W-1:0]   hit_idx;
    logic                   have_free;
    logic [WAY_IDX_W-1:0]   free_idx;
    way_t                   hit_way;

    assign rd_ways   = row_reg[BUCKET_WAYS*WAY_W-1:0];
    assign rd_fill   = row_reg[ROW_W-1 -: FILL_W];
    assign have_free = (rd_fill < WAYS_FILL);
    assign free_idx  = rd_fill[WAY_IDX_W-1:0];
    assign hit_way   = rd_ways[hit_idx];

    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!found && (FILL_W'(w) < rd_fill) && (rd_ways[w].key == addr_reg)) begin
                found   = 1'b1;
                hit_idx = WAY_IDX_W'(w);
            end
        end
    end

    // Update of the row and the result.
    way_t [BUCKET_WAYS-1:0] wr_ways;
    logic [FILL_W-1:0]      wr_fill;
    logic                   row_write;
    logic                   row_insert;
    way_t                   upd_way;
    logic [STAT_W-1:0]      res_status;
    logic [ID_W-1:0]        res_id;
    logic [SEC_W-1:0]       res_sec;
    logic [USEC_W-1:0]      res_usec;
    logic [ID_W-1:0]        next_ident_reg;

    always_comb begin
        wr_ways    = rd_ways;
        wr_fill    = rd_fill;
        row_write  = 1'b0;
        row_insert = 1'b0;
        upd_way    = hit_way;
        res_status = STAT_MISS;
        res_id     = '0;
        res_sec    = '0;
        res_usec   = '0;
        unique case (cmd_reg)
            CMD_POPULATE: begin
                if (have_free) begin
                    wr_ways[free_idx] = '{key: addr_reg, ident: gid_reg, sec: '0, usec: '0};
                    wr_fill    = rd_fill + 1'b1;
                    row_write  = 1'b1;
                    row_insert = 1'b1;
                    res_status = STAT_INSERTED;
                    res_id     = gid_reg;
                end else begin
                    res_status = STAT_FULL;
                end
            end
            CMD_LOOKUP_INSERT: begin
                if (found) begin
                    // An entry created by populate takes its start time on first hit.
                    if (hit_way.sec == '0) begin
                        upd_way.sec      = sec_reg;
                        upd_way.usec     = usec_reg;
                        wr_ways[hit_idx] = upd_way;
                        row_write        = 1'b1;
                    end
                    res_status = STAT_HIT;
                    res_id     = upd_way.ident;
                    res_sec    = upd_way.sec;
                    res_usec   = upd_way.usec;
                end else if (have_free) begin
                    wr_ways[free_idx] = '{key: addr_reg, ident: next_ident_reg,
                                          sec: sec_reg, usec: usec_reg};
                    wr_fill    = rd_fill + 1'b1;
                    row_write  = 1'b1;
                    row_insert = 1'b1;
                    res_status = STAT_INSERTED;
                    res_id     = next_ident_reg;
                    res_sec    = sec_reg;
                    res_usec   = usec_reg;
                end else begin
                    res_status = STAT_FULL;
                end
            end
            default: begin
                // Lookup only; the unused command code behaves the same way.
                if (found) begin
                    res_status = STAT_HIT;
                    res_id     = hit_way.ident;
                    res_sec    = hit_way.sec;
                    res_usec   = hit_way.usec;
                end
            end
        endcase
    end

    assign mem_we    = dp_cmd.clear_en || (dp_cmd.commit_en && row_write);
    assign mem_waddr = dp_cmd.clear_en ? clr_cnt_reg : bucket_reg;
    assign mem_wdata = dp_cmd.clear_en ? '0 : {wr_fill, wr_ways};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_ident_reg <= '0;
        end else if (dp_cmd.commit_en && row_insert) begin
            next_ident_reg <= next_ident_reg + 1'b1;
        end
    end

    // Result register: holds a finished result until its transfer.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dp_cmd.commit_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit_en) begin
            m_tdata_reg <= M_TDATA_W'({res_usec, res_sec, res_id, res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign dp_status.clear_last = (clr_cnt_reg == BKT_W'(NUM_BUCKETS - 1));
    assign dp_status.out_free   = !m_tvalid_reg || m_tready;

endmodule

FILE: design/host_address_table.sv
// Host address table: hash table of IPv4 host addresses, keyed lookup and insert.
// Instantiates hat_ctrl and hat_dp; depends on hat_pkg.
//
// Each request is hashed to a bucket (Horner sum of the address bytes with
// multiplier 13, reduced mod NUM_BUCKETS) and searched over BUCKET_WAYS ways
// that fill in order; commands are lookup-or-insert, populate with a given id,
// and lookup only. One result comes out per request. A request passes through
// these steps before the next request is accepted: the accept, three steps of
// hash and reduction (sum, reciprocal multiply, quotient times bucket count),
// one bucket memory read and one read-modify-write commit; the commit waits
// while an earlier result has not been transferred. After reset the block runs
// a clearing pass over every row of the bucket memory and accepts no request
// until it is done.
module host_address_table
    import hat_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024,
    parameter int BUCKET_WAYS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[1:0], host_address[33:2], given_id[65:34], now_sec[97:66],
    // now_usec[117:98], zero pad[119:118]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], entry_id[33:2], start_sec[65:34], start_usec[85:66],
    // zero pad[87:86]
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_status;

    hat_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    hat_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: design/hat_checker.sv
// Port checker of the host address table, bound to the top level.
// Depends on hat_pkg for payload widths and status codes.
module hat_checker
    import hat_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STAT_W-1:0] m_status;

    assign m_status = m_tdata[STAT_W-1:0];

    // One request at a time: after an input transfer the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in the cycle after an input transfer");

    // A result never appears right after its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared one cycle after an input transfer");

    // Misses and full buckets carry no entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_status == STAT_MISS || m_status == STAT_FULL))
            |-> (m_tdata[M_TDATA_W-1:STAT_W] == '0))
        else $error("miss or full result carries entry fields");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed or dropped while stalled");

endmodule

bind host_address_table hat_checker u_hat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
